// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MBS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MBS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBS_ASSERT(label, clk, rst, prop, msg)
`define MBS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- design/mbs_pkg.sv -----
// ----------------------------------------------------------------------------
// mbs_pkg
// types, codes and crc helper of the modbus rtu holding register slave
// ----------------------------------------------------------------------------
package mbs_pkg;

   localparam int FRAME_BYTES_DEF = 256;
   localparam int NUM_REGS_DEF    = 64;
   localparam int LEN_W           = 9;
   localparam int CSR_AW          = 3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] EXC_FLAG         = 8'h80;
   localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;
   localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'h02;
   localparam logic [7:0] BCAST_ADDR       = 8'h00;
   localparam logic [7:0] FUNC_READ        = 8'h03;
   localparam logic [7:0] FUNC_WRITE       = 8'h10;
   localparam logic [7:0] SLAVE_ADDR_RST   = 8'h01;

   localparam logic CSR_SLAVE_ADDRESS = 1'b0;

   localparam logic [1:0] REQ_BYTE = 2'd0;
   localparam logic [1:0] REQ_END  = 2'd1;
   localparam logic [1:0] REQ_PULL = 2'd2;

   localparam logic [2:0] FS_NONE    = 3'd0;
   localparam logic [2:0] FS_RESP    = 3'd1;
   localparam logic [2:0] FS_SILENT  = 3'd2;
   localparam logic [2:0] FS_BAD     = 3'd3;
   localparam logic [2:0] FS_NOADDR  = 3'd4;

   localparam logic [LEN_W-1:0] MIN_FRAME = 9'd4;
   localparam logic [LEN_W-1:0] READ_LEN  = 9'd8;
   localparam logic [LEN_W-1:0] WRITE_MIN = 9'd7;
   localparam logic [LEN_W-1:0] WRITE_OVH = 9'd9;
   localparam logic [LEN_W-1:0] WDATA_POS = 9'd7;
   localparam logic [LEN_W-1:0] HDR_LAST  = 9'd6;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_byte;
   } mbs_req_type;

   typedef struct packed {
      logic [2:0] frame_status;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       tx_last;
   } mbs_rsp_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      acc = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction

endpackage

// ----- design/mbs_regfile.sv -----
// ----------------------------------------------------------------------------
// mbs_regfile
// holding register memory, one write and one registered read port,
// entries read as zero until first written
// ----------------------------------------------------------------------------
module mbs_regfile #(
   parameter int NUM_REGS = mbs_pkg::NUM_REGS_DEF,
   parameter int RA       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [RA-1:0] waddr,
   input  logic [15:0]   wdata,
   input  logic [RA-1:0] raddr,
   output logic [15:0]   rdata
);
   import mbs_pkg::*;

   logic [15:0]         mem [NUM_REGS];
   logic [NUM_REGS-1:0] vld_ff;
   logic [15:0]         rd_ff;
   logic                rdv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (we) begin
         vld_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff  <= mem[raddr];
      rdv_ff <= vld_ff[raddr];
   end

   assign rdata = rdv_ff ? rd_ff : 16'h0000;

endmodule

// ----- design/modbus_rtu_holding_register_slave_unit.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_holding_register_slave_unit
// modbus rtu slave serving read (03) and write (10) of holding registers
// ----------------------------------------------------------------------------
// byte, empty pull, other request, short frame end: straight to the result (FIN)
// pull: tx buffer read (PULL), then result (FIN); back to idle once it is loaded
// frame end: walk the rx buffer (SCAN) and check (CHECK); a good write then stores
// its registers (WREG); a response sends 3 or 6 header bytes (TXHDR), the
// registers read (RREG) and the crc (TXCRC); one transaction in flight at a time
// reset: control cleared, slave address 1, registers read zero, buffers undefined
`include "assert_macros.svh"
module modbus_rtu_holding_register_slave_unit #(
   parameter int FRAME_BYTES = mbs_pkg::FRAME_BYTES_DEF,
   parameter int NUM_REGS    = mbs_pkg::NUM_REGS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  mbs_pkg::mbs_req_type       req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mbs_pkg::mbs_rsp_type       rsp_payload,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [mbs_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import mbs_pkg::*;

   localparam int FA = $clog2(FRAME_BYTES);
   localparam int RA = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int NW = $clog2(NUM_REGS + 1);
   localparam logic [LEN_W-1:0] FB = LEN_W'(FRAME_BYTES);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SCAN  = 9'b000000010,
      ST_CHECK = 9'b000000100,
      ST_WREG  = 9'b000001000,
      ST_TXHDR = 9'b000010000,
      ST_RREG  = 9'b000100000,
      ST_TXCRC = 9'b001000000,
      ST_PULL  = 9'b010000000,
      ST_FIN   = 9'b100000000
   } mbs_state_type;

   mbs_state_type    state_ff, state_in;
   logic [LEN_W-1:0] rx_len_ff, rx_len_in;
   logic             rx_ovf_ff, rx_ovf_in;
   logic [LEN_W-1:0] tx_len_ff, tx_len_in;
   logic [LEN_W-1:0] tx_pos_ff, tx_pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   mbs_rsp_type      rsp_ff, rsp_in;
   logic [7:0]       saddr_ff;

   logic [LEN_W-1:0] flen_ff, flen_in;
   logic [LEN_W-1:0] k_ff, k_in;
   logic [15:0]      crc_ff, crc_in;
   logic [15:0]      rcrc_ff, rcrc_in;
   logic [7:0]       hdr_ff [0:6];
   logic [7:0]       hdr_in [0:6];
   logic [7:0]       txb_ff [0:5];
   logic [7:0]       txb_in [0:5];
   logic [2:0]       hcnt_ff, hcnt_in;
   logic             is_rd_ff, is_rd_in;
   logic             respond_ff, respond_in;
   mbs_rsp_type      res_ff, res_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic [RA-1:0]    ra_ff, ra_in;
   logic [LEN_W-1:0] rp_ff, rp_in;
   logic [1:0]       ph_ff, ph_in;
   logic [7:0]       hi_ff, hi_in;
   logic [LEN_W-1:0] w_ff, w_in;
   logic [15:0]      tcrc_ff, tcrc_in;

   logic [7:0]       rx_mem [FRAME_BYTES];
   logic [7:0]       tx_mem [FRAME_BYTES];
   logic [7:0]       rx_rd_ff;
   logic [7:0]       tx_rd_ff;
   logic             rx_we;
   logic [FA-1:0]    rx_raddr;
   logic             tx_put;
   logic             tx_we;
   logic [7:0]       tx_wdata;
   logic [FA-1:0]    tx_raddr;
   logic             reg_we;
   logic [RA-1:0]    reg_raddr;
   logic [15:0]      reg_rdata;

   logic [15:0]      start_w;
   logic [15:0]      num_w;
   logic [16:0]      sum_w;
   logic             range_ok;
   logic             rd_ok;
   logic             wr_ok;
   logic             crc_ok;
   logic             addr_ok;
   logic             respond_w;
   logic             out_free;

   assign start_w   = {hdr_ff[2], hdr_ff[3]};
   assign num_w     = {hdr_ff[4], hdr_ff[5]};
   assign sum_w     = {1'b0, start_w} + {1'b0, num_w};
   assign range_ok  = (num_w != 16'h0000) && (sum_w <= 17'(NUM_REGS));
   assign rd_ok     = (flen_ff == READ_LEN) && range_ok;
   assign wr_ok     = (flen_ff >= WRITE_MIN) && range_ok
                      && ({9'b0, hdr_ff[6]} == {num_w, 1'b0})
                      && (flen_ff == WRITE_OVH + {1'b0, hdr_ff[6]});
   assign crc_ok    = (crc_ff == rcrc_ff);
   assign addr_ok   = (hdr_ff[0] == saddr_ff) || (hdr_ff[0] == BCAST_ADDR);
   assign respond_w = (hdr_ff[0] != BCAST_ADDR);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign tx_we       = tx_put && (w_ff < FB);

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_SLAVE_ADDRESS) ? {24'h000000, saddr_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         saddr_ff <= SLAVE_ADDR_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == CSR_SLAVE_ADDRESS) begin
         saddr_ff <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      rx_len_in    = rx_len_ff;
      rx_ovf_in    = rx_ovf_ff;
      tx_len_in    = tx_len_ff;
      tx_pos_in    = tx_pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      flen_in      = flen_ff;
      k_in         = k_ff;
      crc_in       = crc_ff;
      rcrc_in      = rcrc_ff;
      hdr_in       = hdr_ff;
      txb_in       = txb_ff;
      hcnt_in      = hcnt_ff;
      is_rd_in     = is_rd_ff;
      respond_in   = respond_ff;
      res_in       = res_ff;
      cnt_in       = cnt_ff;
      ra_in        = ra_ff;
      rp_in        = rp_ff;
      ph_in        = ph_ff;
      hi_in        = hi_ff;
      w_in         = w_ff;
      tcrc_in      = tcrc_ff;
      rx_we        = 1'b0;
      rx_raddr     = '0;
      tx_put       = 1'b0;
      tx_wdata     = 8'h00;
      tx_raddr     = tx_pos_ff[FA-1:0];
      reg_we       = 1'b0;
      reg_raddr    = ra_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in   = '0;
               state_in = ST_FIN;
               case (req_payload.req_type)
                  REQ_BYTE: begin
                     if (rx_len_ff < FB) begin
                        rx_we     = 1'b1;
                        rx_len_in = rx_len_ff + 1'b1;
                     end else begin
                        rx_ovf_in = 1'b1;
                     end
                  end
                  REQ_END: begin
                     flen_in   = rx_len_ff;
                     rx_len_in = '0;
                     rx_ovf_in = 1'b0;
                     if (rx_ovf_ff || rx_len_ff < MIN_FRAME) begin
                        res_in.frame_status = FS_BAD;
                     end else begin
                        k_in     = '0;
                        crc_in   = CRC_INIT;
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_PULL: begin
                     if (tx_pos_ff < tx_len_ff && tx_pos_ff < FB) begin
                        state_in = ST_PULL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (k_ff < flen_ff - 2'd2) begin
               crc_in = crc_byte(crc_ff, rx_rd_ff);
            end
            if (k_ff == flen_ff - 2'd2) begin
               rcrc_in[7:0] = rx_rd_ff;
            end
            if (k_ff == flen_ff - 1'b1) begin
               rcrc_in[15:8] = rx_rd_ff;
               state_in      = ST_CHECK;
            end
            if (k_ff <= HDR_LAST) begin
               hdr_in[k_ff[2:0]] = rx_rd_ff;
            end
            k_in     = k_ff + 1'b1;
            rx_raddr = k_in[FA-1:0];
         end
         ST_CHECK: begin
            tcrc_in    = CRC_INIT;
            w_in       = '0;
            k_in       = '0;
            ph_in      = 2'd0;
            rp_in      = WDATA_POS;
            ra_in      = start_w[RA-1:0];
            cnt_in     = num_w[NW-1:0];
            respond_in = respond_w;
            txb_in[0]  = hdr_ff[0];
            txb_in[1]  = hdr_ff[1] | EXC_FLAG;
            txb_in[2]  = EXC_ILLEGAL_FUNC;
            hcnt_in    = 3'd3;
            is_rd_in   = 1'b0;
            state_in   = ST_FIN;
            if (!crc_ok) begin
               res_in.frame_status = FS_BAD;
            end else if (!addr_ok) begin
               res_in.frame_status = FS_NOADDR;
            end else begin
               res_in.frame_status = respond_w ? FS_RESP : FS_SILENT;
               if (respond_w) begin
                  state_in = ST_TXHDR;
               end
               if (hdr_ff[1] == FUNC_READ && rd_ok) begin
                  txb_in[1] = hdr_ff[1];
                  txb_in[2] = {num_w[6:0], 1'b0};
                  is_rd_in  = 1'b1;
               end else if (hdr_ff[1] == FUNC_WRITE && wr_ok) begin
                  for (int i = 0; i < 6; i++) begin
                     txb_in[i] = hdr_ff[i];
                  end
                  hcnt_in  = 3'd6;
                  state_in = ST_WREG;
               end else if (hdr_ff[1] == FUNC_READ || hdr_ff[1] == FUNC_WRITE) begin
                  txb_in[2] = EXC_ILLEGAL_ADDR;
               end
            end
         end
         ST_WREG: begin
            case (ph_ff)
               2'd0: begin
                  rx_raddr = rp_ff[FA-1:0];
                  ph_in    = 2'd1;
               end
               2'd1: begin
                  hi_in    = rx_rd_ff;
                  rx_raddr = rp_ff[FA-1:0] + 1'b1;
                  ph_in    = 2'd2;
               end
               default: begin
                  reg_we = 1'b1;
                  ra_in  = ra_ff + 1'b1;
                  rp_in  = rp_ff + 2'd2;
                  cnt_in = cnt_ff - 1'b1;
                  ph_in  = 2'd0;
                  if (cnt_ff == NW'(1)) begin
                     state_in = respond_ff ? ST_TXHDR : ST_FIN;
                  end
               end
            endcase
         end
         ST_TXHDR: begin
            tx_put   = 1'b1;
            tx_wdata = txb_ff[k_ff[2:0]];
            tcrc_in  = crc_byte(tcrc_ff, tx_wdata);
            w_in     = w_ff + 1'b1;
            k_in     = k_ff + 1'b1;
            ph_in    = 2'd0;
            if (k_ff == {6'b0, hcnt_ff} - 1'b1) begin
               state_in = is_rd_ff ? ST_RREG : ST_TXCRC;
            end
         end
         ST_RREG: begin
            case (ph_ff)
               2'd0: begin
                  ph_in = 2'd1;
               end
               2'd1: begin
                  tx_put   = 1'b1;
                  tx_wdata = reg_rdata[15:8];
                  tcrc_in  = crc_byte(tcrc_ff, tx_wdata);
                  w_in     = w_ff + 1'b1;
                  ph_in    = 2'd2;
               end
               default: begin
                  tx_put   = 1'b1;
                  tx_wdata = reg_rdata[7:0];
                  tcrc_in  = crc_byte(tcrc_ff, tx_wdata);
                  w_in     = w_ff + 1'b1;
                  ra_in    = ra_ff + 1'b1;
                  cnt_in   = cnt_ff - 1'b1;
                  ph_in    = 2'd0;
                  if (cnt_ff == NW'(1)) begin
                     state_in = ST_TXCRC;
                  end
               end
            endcase
         end
         ST_TXCRC: begin
            tx_put = 1'b1;
            if (ph_ff == 2'd0) begin
               tx_wdata = tcrc_ff[7:0];
               w_in     = w_ff + 1'b1;
               ph_in    = 2'd1;
            end else begin
               tx_wdata  = tcrc_ff[15:8];
               tx_len_in = w_ff + 1'b1;
               tx_pos_in = '0;
               state_in  = ST_FIN;
            end
         end
         ST_PULL: begin
            res_in.tx_valid = 1'b1;
            res_in.tx_byte  = tx_rd_ff;
            res_in.tx_last  = (tx_pos_ff + 1'b1 == tx_len_ff);
            tx_pos_in       = tx_pos_ff + 1'b1;
            state_in        = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rx_len_ff    <= '0;
         rx_ovf_ff    <= 1'b0;
         tx_len_ff    <= '0;
         tx_pos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rx_len_ff    <= rx_len_in;
         rx_ovf_ff    <= rx_ovf_in;
         tx_len_ff    <= tx_len_in;
         tx_pos_ff    <= tx_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      flen_ff    <= flen_in;
      k_ff       <= k_in;
      crc_ff     <= crc_in;
      rcrc_ff    <= rcrc_in;
      hdr_ff     <= hdr_in;
      txb_ff     <= txb_in;
      hcnt_ff    <= hcnt_in;
      is_rd_ff   <= is_rd_in;
      respond_ff <= respond_in;
      res_ff     <= res_in;
      cnt_ff     <= cnt_in;
      ra_ff      <= ra_in;
      rp_ff      <= rp_in;
      ph_ff      <= ph_in;
      hi_ff      <= hi_in;
      w_ff       <= w_in;
      tcrc_ff    <= tcrc_in;
   end

   // receive and transmit frame buffers
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_len_ff[FA-1:0]] <= req_payload.rx_byte;
      end
      rx_rd_ff <= rx_mem[rx_raddr];
   end

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[w_ff[FA-1:0]] <= tx_wdata;
      end
      tx_rd_ff <= tx_mem[tx_raddr];
   end

   mbs_regfile #(
      .NUM_REGS (NUM_REGS),
      .RA       (RA)
   ) u_regfile (
      .clock (clock),
      .reset (reset),
      .we    (reg_we),
      .waddr (ra_ff),
      .wdata ({hi_ff, rx_rd_ff}),
      .raddr (reg_raddr),
      .rdata (reg_rdata)
   );

   `MBS_ASSERT(a_rx_len_bound, clock, reset, (rx_len_ff <= FB), "rx length beyond buffer")
   `MBS_ASSERT(a_tx_pos_bound, clock, reset, (tx_pos_ff <= tx_len_ff), "tx position past end")
   `MBS_ASSERT(a_scan_min_len, clock, reset, (state_ff == ST_SCAN) |-> (flen_ff >= MIN_FRAME), "scan of short frame")
   `MBS_ASSERT_NR(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "not idle after reset")

endmodule

// ----- test/modbus_rtu_holding_register_slave_unit_test.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_holding_register_slave_unit_test
// drives received bytes, frame ends and response pulls into the slave and
// checks every result transaction against a behavioral predictor, across
// several station addresses, random idling on both channels and a long stall
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module modbus_rtu_holding_register_slave_unit_test;
   import mbs_pkg::*;

   localparam int NREGS = 64;
   localparam int FBYTES = 256;
   localparam longint CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   mbs_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mbs_rsp_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   modbus_rtu_holding_register_slave_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   logic [7:0]  station_addr;
   logic [7:0]  rx_buf [FBYTES];
   int          rx_count;
   bit          rx_overrun;
   logic [15:0] pred_regs [NREGS];
   logic [7:0]  tx_buf [FBYTES];
   int          tx_count;
   int          tx_next;

   mbs_rsp_type expected_results[$];
   int  fail_count = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_off = 1'b0;
   longint cycle_count = 0;

   function automatic logic [15:0] crc16(input logic [7:0] buf_in[FBYTES], input int n);
      logic [15:0] acc;
      acc = CRC_INIT;
      for (int k = 0; k < n; k++) begin
         acc = acc ^ {8'h00, buf_in[k]};
         for (int b = 0; b < 8; b++) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
         end
      end
      return acc;
   endfunction

   function automatic void arm_tx(input int body);
      logic [15:0] c;
      c = crc16(tx_buf, body);
      tx_buf[body] = c[7:0];
      tx_buf[body+1] = c[15:8];
      tx_count = body + 2;
      tx_next = 0;
   endfunction

   function automatic void arm_exception(input logic [7:0] a, input logic [7:0] f,
                                         input logic [7:0] code);
      tx_buf[0] = a;
      tx_buf[1] = f | EXC_FLAG;
      tx_buf[2] = code;
      arm_tx(3);
   endfunction

   function automatic logic [2:0] close_frame();
      int len, start, num;
      bit ovf, respond;
      logic [7:0] a, f;
      len = rx_count;
      ovf = rx_overrun;
      rx_count = 0;
      rx_overrun = 1'b0;
      if (ovf || len < 4) return FS_BAD;
      if (crc16(rx_buf, len - 2) != {rx_buf[len-1], rx_buf[len-2]}) return FS_BAD;
      a = rx_buf[0];
      f = rx_buf[1];
      if (a != station_addr && a != BCAST_ADDR) return FS_NOADDR;
      respond = (a != BCAST_ADDR);
      start = {rx_buf[2], rx_buf[3]};
      num = {rx_buf[4], rx_buf[5]};
      if (f == FUNC_READ) begin
         if (len != 8 || num == 0 || start + num > NREGS) begin
            if (!respond) return FS_SILENT;
            arm_exception(a, f, EXC_ILLEGAL_ADDR);
            return FS_RESP;
         end
         if (!respond) return FS_SILENT;
         tx_buf[0] = a;
         tx_buf[1] = f;
         tx_buf[2] = 8'(num * 2);
         for (int k = 0; k < num; k++) begin
            tx_buf[3+2*k] = pred_regs[start+k][15:8];
            tx_buf[4+2*k] = pred_regs[start+k][7:0];
         end
         arm_tx(3 + 2 * num);
         return FS_RESP;
      end
      if (f == FUNC_WRITE) begin
         if (len < 7 || num == 0 || int'(rx_buf[6]) != num * 2 || start + num > NREGS
             || len != 9 + int'(rx_buf[6])) begin
            if (!respond) return FS_SILENT;
            arm_exception(a, f, EXC_ILLEGAL_ADDR);
            return FS_RESP;
         end
         for (int k = 0; k < num; k++) begin
            pred_regs[start+k] = {rx_buf[7+2*k], rx_buf[8+2*k]};
         end
         if (!respond) return FS_SILENT;
         for (int k = 0; k < 6; k++) tx_buf[k] = rx_buf[k];
         arm_tx(6);
         return FS_RESP;
      end
      if (!respond) return FS_SILENT;
      arm_exception(a, f, EXC_ILLEGAL_FUNC);
      return FS_RESP;
   endfunction

   function automatic mbs_rsp_type predict_slave(input mbs_req_type t);
      mbs_rsp_type r;
      r = '0;
      if (t.req_type == REQ_BYTE) begin
         if (rx_count < FBYTES) begin
            rx_buf[rx_count] = t.rx_byte;
            rx_count++;
         end else begin
            rx_overrun = 1'b1;
         end
      end else if (t.req_type == REQ_END) begin
         r.frame_status = close_frame();
      end else if (t.req_type == REQ_PULL) begin
         if (tx_next < tx_count) begin
            r.tx_valid = 1'b1;
            r.tx_byte = tx_buf[tx_next];
            r.tx_last = (tx_next + 1 == tx_count);
            tx_next++;
         end
      end
      return r;
   endfunction

   // send one transaction, with optional preset expectation
   task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                            input bit has_fixed, input mbs_rsp_type fixed);
      mbs_req_type t;
      mbs_rsp_type p;
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      t.req_type = kind;
      t.rx_byte = data;
      req_payload = t;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_slave(t);
      if (has_fixed && p != fixed) begin
         $error("table row: field predictor expected %h actual %h", fixed, p);
         fail_count++;
      end
      expected_results.push_back(p);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_plain(input logic [1:0] kind, input logic [7:0] data);
      send_item(kind, data, 1'b0, '0);
   endtask

   // send a whole frame with its crc, corrupted unless good_crc, then frame end
   task automatic send_frame(input logic [7:0] bytes[$], input bit good_crc);
      logic [7:0] tmp[FBYTES];
      logic [15:0] c;
      foreach (bytes[k]) tmp[k] = bytes[k];
      c = crc16(tmp, bytes.size());
      if (!good_crc) c ^= 16'(1 << $urandom_range(15));
      foreach (bytes[k]) send_plain(REQ_BYTE, bytes[k]);
      send_plain(REQ_BYTE, c[7:0]);
      send_plain(REQ_BYTE, c[15:8]);
      send_plain(REQ_END, 8'(($urandom())));
   endtask

   task automatic pull_all(input int n);
      for (int k = 0; k < n; k++) send_plain(REQ_PULL, 8'($urandom()));
   endtask

   task automatic write_station(input logic [7:0] a);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (1200) @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {CSR_SLAVE_ADDRESS, 2'b00};
      csr_pwdata <= {24'h0, a};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      station_addr = a;
   endtask

   task automatic random_request(input logic [7:0] a);
      logic [7:0] q[$];
      int start, num, pick;
      pick = $urandom_range(99);
      q = {};
      if ($urandom_range(3) == 0) start = $urandom_range(NREGS + 3);
      else start = $urandom_range(NREGS - 1);
      num = ($urandom_range(5) == 0) ? $urandom_range(NREGS + 2) : $urandom_range(1, 6);
      if (start + num > NREGS && $urandom_range(1)) num = NREGS - start;
      if (num < 0) num = 0;
      if (pick < 40) begin
         q = {a, FUNC_READ, 8'(start >> 8), 8'(start), 8'(num >> 8), 8'(num)};
         if ($urandom_range(15) == 0) q.push_back(8'($urandom()));
      end else if (pick < 80) begin
         if (num > 20) num = $urandom_range(1, 3);
         q = {a, FUNC_WRITE, 8'(start >> 8), 8'(start), 8'(num >> 8), 8'(num), 8'(num * 2)};
         if ($urandom_range(15) == 0) q[6] = 8'($urandom());
         for (int k = 0; k < 2 * num; k++) q.push_back(8'($urandom()));
         if ($urandom_range(15) == 0) void'(q.pop_back());
      end else if (pick < 90) begin
         q = {a, 8'($urandom())};
         repeat ($urandom_range(6)) q.push_back(8'($urandom()));
      end else begin
         repeat ($urandom_range(4)) q.push_back(8'($urandom()));
         foreach (q[k]) send_plain(REQ_BYTE, q[k]);
         send_plain(REQ_END, 8'($urandom()));
         return;
      end
      send_frame(q, $urandom_range(19) != 0);
      if ($urandom_range(9) != 0) pull_all($urandom_range(3, 30));
   endtask

   function automatic logic [7:0] pick_addr();
      int p;
      p = $urandom_range(9);
      if (p < 7) return station_addr;
      if (p < 8) return BCAST_ADDR;
      return 8'($urandom());
   endfunction

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  data;
      bit          has_fixed;
      mbs_rsp_type fixed;
   } stim_row;

   stim_row directed_rows[$];

   initial begin
      logic [7:0] q[$];
      station_addr = SLAVE_ADDR_RST;
      rx_count = 0;
      rx_overrun = 1'b0;
      tx_count = 0;
      tx_next = 0;
      foreach (pred_regs[k]) pred_regs[k] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 78;

      // directed table: after reset, short frames, idle request type, extremes
      directed_rows = '{
         '{REQ_PULL, 8'hff, 1'b1, '0},
         '{REQ_END,  8'h00, 1'b1, '{frame_status: FS_BAD, default: '0}},
         '{REQ_BYTE, 8'h00, 1'b1, '0},
         '{REQ_BYTE, 8'hff, 1'b1, '0},
         '{REQ_BYTE, 8'h55, 1'b1, '0},
         '{REQ_END,  8'hff, 1'b1, '{frame_status: FS_BAD, default: '0}},
         '{2'd3,     8'hff, 1'b1, '0},
         '{2'd3,     8'h00, 1'b1, '0},
         '{REQ_PULL, 8'h00, 1'b1, '0}
      };
      foreach (directed_rows[k])
         send_item(directed_rows[k].kind, directed_rows[k].data,
                   directed_rows[k].has_fixed, directed_rows[k].fixed);
      q = {SLAVE_ADDR_RST, FUNC_WRITE, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'hff, 8'hff};
      send_frame(q, 1'b1);
      pull_all(9);
      q = {SLAVE_ADDR_RST, FUNC_READ, 8'h00, 8'h00, 8'h00, 8'h01};
      send_frame(q, 1'b1);
      pull_all(7);
      q = {SLAVE_ADDR_RST, FUNC_READ, 8'h00, 8'h3f, 8'h00, 8'h02};
      send_frame(q, 1'b1);
      pull_all(5);
      q = {SLAVE_ADDR_RST, 8'h7f};
      send_frame(q, 1'b1);
      pull_all(5);
      q = {BCAST_ADDR, FUNC_WRITE, 8'h00, 8'h3f, 8'h00, 8'h01, 8'h02, 8'h12, 8'h34};
      send_frame(q, 1'b1);
      q = {8'hf7, FUNC_READ, 8'h00, 8'h00, 8'h00, 8'h01};
      send_frame(q, 1'b1);
      // overflow: more bytes than the buffer holds
      repeat (FBYTES + 3) send_plain(REQ_BYTE, 8'($urandom()));
      send_plain(REQ_END, 8'h00);
      pull_all(2);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            write_station(8'hf7);
            send_idle_pct = 78;
            recv_idle_pct = 11;
         end
         if (phase == 2) begin
            write_station(8'h01);
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_off = 1'b1;
         end
         for (int n = 0; n < 14; n++) begin
            if (phase == 0 && n == 9) write_station(8'($urandom_range(2, 246)));
            random_request(pick_addr());
         end
         if (phase == 2) begin
            // a full read, the largest response
            q = {station_addr, FUNC_READ, 8'h00, 8'h00, 8'h00, 8'(NREGS)};
            send_frame(q, 1'b1);
            pull_all(2 * NREGS + 6);
         end
      end

      while (expected_results.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // receiver stall, and one long hold-off
   initial begin
      int held;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_off && held < 400) begin
            rsp_stall <= 1'b1;
            held++;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      mbs_rsp_type e;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result %h", rsp_payload);
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_payload.frame_status !== e.frame_status) begin
               $error("frame_status expected %0d actual %0d",
                      e.frame_status, rsp_payload.frame_status);
               fail_count++;
            end
            if (rsp_payload.tx_valid !== e.tx_valid) begin
               $error("tx_valid expected %0d actual %0d", e.tx_valid, rsp_payload.tx_valid);
               fail_count++;
            end
            if (rsp_payload.tx_byte !== e.tx_byte) begin
               $error("tx_byte expected %h actual %h", e.tx_byte, rsp_payload.tx_byte);
               fail_count++;
            end
            if (rsp_payload.tx_last !== e.tx_last) begin
               $error("tx_last expected %0d actual %0d", e.tx_last, rsp_payload.tx_last);
               fail_count++;
            end
         end
      end
   end
endmodule
